// File: rtl/mcpp_pkg.sv
// Shared types and constants for the MQTT control packet parser.
package mcpp_pkg;

  localparam logic [3:0] TYPE_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] TYPE_UNSUBSCRIBE = 4'd10;
  localparam logic [3:0] TYPE_PINGREQ     = 4'd12;
  localparam logic [3:0] TYPE_DISCONNECT  = 4'd14;
  localparam logic [3:0] FLAGS_SUB        = 4'd2;

  localparam logic [7:0] HDR_SUBACK   = 8'h90;
  localparam logic [7:0] HDR_UNSUBACK = 8'hB0;
  localparam logic [7:0] HDR_PINGRESP = 8'hD0;
  localparam logic [7:0] LEN_ACK      = 8'h02;
  localparam logic [7:0] LEN_PINGRESP = 8'h00;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BODY  = 1'b1;

  localparam logic ACT_SEND  = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID_HI,
    PH_ID_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_TOPIC,
    PH_QOS
  } phase_e;

  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_CLOSE,
    RESP_PING,
    RESP_ACK
  } resp_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic step;   // apply the accepted input word
    logic fetch;  // read the code buffer for the current response word
    logic send;   // load the current response word into the output register
  } cmd_t;

  typedef struct packed {
    logic has_resp;   // the input word on the port produces a response
    logic last_word;  // current response word is the final one
    logic out_free;   // output register can take a word this cycle
  } sts_t;

endpackage

// File: rtl/mcpp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mcpp_datapath.sv
// Datapath: packet parse registers, return code buffer, response byte mux, output register.
module mcpp_datapath #(
  parameter int MAX_FILTERS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mcpp_pkg::cmd_t   cmd_i,
  output mcpp_pkg::sts_t   sts_o,
  input  logic             in_kind_i,
  input  logic [7:0]       in_header_byte_i,
  input  logic [15:0]      in_remaining_length_i,
  input  logic [7:0]       in_body_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_action_o,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  localparam int AW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int CW = $clog2(MAX_FILTERS + 1);
  localparam int IW = $clog2(MAX_FILTERS + 5);

  logic [3:0]          type_q, type_d;
  logic                skip_q, skip_d;
  mcpp_pkg::phase_e    phase_q, phase_d;
  logic [15:0]         bl_q, bl_d;
  logic [15:0]         tl_q, tl_d;
  logic [15:0]         ident_q, ident_d;
  logic [CW-1:0]       cc_q, cc_d;
  mcpp_pkg::resp_e     resp_q, resp_d;
  logic [IW-1:0]       idx_q;

  logic                out_valid_q;
  logic                out_action_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q;

  logic                ram_we;
  logic [7:0]          ram_rdata;
  logic [IW-1:0]       code_idx;
  logic [IW-1:0]       last_idx;
  logic                sub;
  logic [15:0]         bl_n;
  logic [15:0]         tl_n;
  logic [15:0]         tl_dec;
  logic [7:0]          word_byte;
  logic                word_action;

  assign sub   = (type_q == mcpp_pkg::TYPE_SUBSCRIBE);
  assign bl_n  = bl_q - 16'd1;
  assign tl_n  = {tl_q[15:8], in_body_byte_i};
  assign tl_dec = (tl_q != 16'd0) ? (tl_q - 16'd1) : tl_q;

  // One parse step per accepted input word.
  always_comb begin
    type_d  = type_q;
    skip_d  = skip_q;
    phase_d = phase_q;
    bl_d    = bl_q;
    tl_d    = tl_q;
    ident_d = ident_q;
    cc_d    = cc_q;
    resp_d  = mcpp_pkg::RESP_NONE;
    ram_we  = 1'b0;
    if (in_kind_i == mcpp_pkg::KIND_START) begin
      type_d  = in_header_byte_i[7:4];
      bl_d    = in_remaining_length_i;
      tl_d    = '0;
      ident_d = '0;
      cc_d    = '0;
      phase_d = mcpp_pkg::PH_IDLE;
      skip_d  = (in_remaining_length_i != 16'd0);
      if ((in_header_byte_i[7:4] == mcpp_pkg::TYPE_SUBSCRIBE) ||
          (in_header_byte_i[7:4] == mcpp_pkg::TYPE_UNSUBSCRIBE)) begin
        if ((in_header_byte_i[3:0] != mcpp_pkg::FLAGS_SUB) ||
            (in_remaining_length_i < 16'd2)) begin
          resp_d = mcpp_pkg::RESP_CLOSE;
        end else begin
          skip_d  = 1'b0;
          phase_d = mcpp_pkg::PH_ID_HI;
        end
      end else if (in_header_byte_i[7:4] == mcpp_pkg::TYPE_PINGREQ) begin
        resp_d = mcpp_pkg::RESP_PING;
      end else if (in_header_byte_i[7:4] == mcpp_pkg::TYPE_DISCONNECT) begin
        resp_d = mcpp_pkg::RESP_CLOSE;
      end
    end else if (skip_q) begin
      if (bl_q != 16'd0) begin
        bl_d = bl_n;
      end
      if ((bl_q == 16'd0) || (bl_n == 16'd0)) begin
        skip_d = 1'b0;
      end
    end else if ((phase_q == mcpp_pkg::PH_IDLE) || (bl_q == 16'd0)) begin
      phase_d = mcpp_pkg::PH_IDLE;
    end else begin
      bl_d = bl_n;
      case (phase_q)
        mcpp_pkg::PH_ID_HI: begin
          ident_d = {in_body_byte_i, 8'h00};
          phase_d = mcpp_pkg::PH_ID_LO;
        end
        mcpp_pkg::PH_ID_LO: begin
          ident_d = {ident_q[15:8], in_body_byte_i};
          if (bl_n == 16'd0) begin
            resp_d  = mcpp_pkg::RESP_ACK;
            phase_d = mcpp_pkg::PH_IDLE;
            skip_d  = 1'b0;
          end else begin
            phase_d = mcpp_pkg::PH_LEN_HI;
          end
        end
        mcpp_pkg::PH_LEN_HI: begin
          if (bl_n == 16'd0) begin
            resp_d  = mcpp_pkg::RESP_CLOSE;
            phase_d = mcpp_pkg::PH_IDLE;
            skip_d  = 1'b0;
          end else begin
            tl_d    = {in_body_byte_i, 8'h00};
            phase_d = mcpp_pkg::PH_LEN_LO;
          end
        end
        mcpp_pkg::PH_LEN_LO: begin
          tl_d = tl_n;
          if (({1'b0, tl_n} + 17'(sub)) > {1'b0, bl_n}) begin
            resp_d  = mcpp_pkg::RESP_CLOSE;
            phase_d = mcpp_pkg::PH_IDLE;
            skip_d  = (bl_n != 16'd0);
          end else if (tl_n != 16'd0) begin
            phase_d = mcpp_pkg::PH_TOPIC;
          end else if (sub) begin
            phase_d = mcpp_pkg::PH_QOS;
          end else if (bl_n == 16'd0) begin
            resp_d  = mcpp_pkg::RESP_ACK;
            phase_d = mcpp_pkg::PH_IDLE;
            skip_d  = 1'b0;
          end else begin
            phase_d = mcpp_pkg::PH_LEN_HI;
          end
        end
        mcpp_pkg::PH_TOPIC: begin
          tl_d = tl_dec;
          if (tl_dec != 16'd0) begin
            phase_d = mcpp_pkg::PH_TOPIC;
          end else if (sub) begin
            phase_d = mcpp_pkg::PH_QOS;
          end else if (bl_n == 16'd0) begin
            resp_d  = mcpp_pkg::RESP_ACK;
            phase_d = mcpp_pkg::PH_IDLE;
            skip_d  = 1'b0;
          end else begin
            phase_d = mcpp_pkg::PH_LEN_HI;
          end
        end
        mcpp_pkg::PH_QOS: begin
          if (cc_q >= CW'(MAX_FILTERS)) begin
            resp_d  = mcpp_pkg::RESP_CLOSE;
            phase_d = mcpp_pkg::PH_IDLE;
            skip_d  = (bl_n != 16'd0);
          end else begin
            ram_we = 1'b1;
            cc_d   = cc_q + CW'(1);
            if (bl_n == 16'd0) begin
              resp_d  = mcpp_pkg::RESP_ACK;
              phase_d = mcpp_pkg::PH_IDLE;
              skip_d  = 1'b0;
            end else begin
              phase_d = mcpp_pkg::PH_LEN_HI;
            end
          end
        end
        default: begin
          phase_d = mcpp_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q  <= '0;
      skip_q  <= 1'b0;
      phase_q <= mcpp_pkg::PH_IDLE;
      bl_q    <= '0;
      tl_q    <= '0;
      ident_q <= '0;
      cc_q    <= '0;
      resp_q  <= mcpp_pkg::RESP_NONE;
      idx_q   <= '0;
    end else begin
      if (cmd_i.step) begin
        type_q  <= type_d;
        skip_q  <= skip_d;
        phase_q <= phase_d;
        bl_q    <= bl_d;
        tl_q    <= tl_d;
        ident_q <= ident_d;
        cc_q    <= cc_d;
        resp_q  <= resp_d;
        idx_q   <= '0;
      end else if (cmd_i.send) begin
        idx_q <= idx_q + IW'(1);
      end
    end
  end

  assign code_idx = idx_q - IW'(4);

  mcpp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FILTERS)
  ) u_codes (
    .clk_i   (clk_i),
    .we_i    (cmd_i.step && ram_we),
    .waddr_i (cc_q[AW-1:0]),
    .wdata_i (in_body_byte_i),
    .re_i    (cmd_i.fetch),
    .raddr_i (code_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (resp_q)
      mcpp_pkg::RESP_PING: last_idx = IW'(1);
      mcpp_pkg::RESP_ACK:  last_idx = sub ? (IW'(3) + IW'(cc_q)) : IW'(3);
      default:             last_idx = '0;
    endcase
  end

  always_comb begin
    word_action = mcpp_pkg::ACT_SEND;
    word_byte   = 8'h00;
    case (resp_q)
      mcpp_pkg::RESP_CLOSE: begin
        word_action = mcpp_pkg::ACT_CLOSE;
      end
      mcpp_pkg::RESP_PING: begin
        word_byte = (idx_q == '0) ? mcpp_pkg::HDR_PINGRESP : mcpp_pkg::LEN_PINGRESP;
      end
      mcpp_pkg::RESP_ACK: begin
        if (idx_q == IW'(0)) begin
          word_byte = sub ? mcpp_pkg::HDR_SUBACK : mcpp_pkg::HDR_UNSUBACK;
        end else if (idx_q == IW'(1)) begin
          word_byte = sub ? (8'(cc_q) + mcpp_pkg::LEN_ACK) : mcpp_pkg::LEN_ACK;
        end else if (idx_q == IW'(2)) begin
          word_byte = ident_q[15:8];
        end else if (idx_q == IW'(3)) begin
          word_byte = ident_q[7:0];
        end else begin
          word_byte = ram_rdata;
        end
      end
      default: begin
        word_byte = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.send) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.send) begin
      out_action_q <= word_action;
      out_byte_q   <= word_byte;
      out_last_q   <= (idx_q == last_idx);
    end
  end

  always_comb begin
    sts_o.has_resp  = (resp_d != mcpp_pkg::RESP_NONE);
    sts_o.last_word = (idx_q == last_idx);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_action_o = out_action_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;

endmodule

// File: rtl/mcpp_ctrl.sv
// Controller: accepts input words and sequences response emission.
module mcpp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mcpp_pkg::sts_t sts_i,
  output mcpp_pkg::cmd_t cmd_o
);

  mcpp_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      mcpp_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.has_resp) begin
          state_d = mcpp_pkg::ST_FETCH;
        end
      end
      mcpp_pkg::ST_FETCH: begin
        state_d = mcpp_pkg::ST_SEND;
      end
      mcpp_pkg::ST_SEND: begin
        if (sts_i.out_free) begin
          state_d = sts_i.last_word ? mcpp_pkg::ST_IDLE : mcpp_pkg::ST_FETCH;
        end
      end
      default: begin
        state_d = mcpp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      mcpp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.step = in_valid_i;
      end
      mcpp_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      mcpp_pkg::ST_SEND: begin
        cmd_o.send = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcpp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/mqtt_control_packet_parser_core.sv
// Throughput: one input word per cycle while no response is produced. A word causing a
// response moves the controller through FETCH, then SEND, which loads the output register.
// Each response word takes a code buffer read (FETCH), then an output load (SEND); input is
// held off until the final word is in the output register. Close is 1 word, PINGRESP 2,
// UNSUBACK 4, SUBACK 4 + filter count. Reset is asynchronous, active low, clears control
// state; the return code buffer is not cleared and its data is used only where written.
module mqtt_control_packet_parser_core #(
  parameter int MAX_FILTERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // header_byte[7:0], remaining_length[23:8], body_byte[31:24]
  input  logic        s_axis_tuser_i,  // kind[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // out_byte[7:0]
  output logic        m_axis_tuser_o,  // action[0]
  output logic        m_axis_tlast_o
);

  mcpp_pkg::cmd_t cmd;
  mcpp_pkg::sts_t sts;

  mcpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcpp_datapath #(
    .MAX_FILTERS (MAX_FILTERS)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .in_kind_i             (s_axis_tuser_i),
    .in_header_byte_i      (s_axis_tdata_i[7:0]),
    .in_remaining_length_i (s_axis_tdata_i[23:8]),
    .in_body_byte_i        (s_axis_tdata_i[31:24]),
    .out_valid_o           (m_axis_tvalid_o),
    .out_ready_i           (m_axis_tready_i),
    .out_action_o          (m_axis_tuser_o),
    .out_byte_o            (m_axis_tdata_o),
    .out_last_o            (m_axis_tlast_o)
  );

  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == mcpp_pkg::ACT_CLOSE)) |-> m_axis_tlast_o)
    else $error("close word without tlast");

  a_close_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == mcpp_pkg::ACT_CLOSE)) |-> (m_axis_tdata_o == 8'h00))
    else $error("close word with nonzero data");

  a_resp_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == mcpp_pkg::KIND_START) &&
     ((s_axis_tdata_i[7:4] == mcpp_pkg::TYPE_PINGREQ) ||
      (s_axis_tdata_i[7:4] == mcpp_pkg::TYPE_DISCONNECT))) |=> !s_axis_tready_o)
    else $error("input taken while response pending");

  a_body_no_close_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == mcpp_pkg::KIND_START) &&
     (s_axis_tdata_i[7:4] == mcpp_pkg::TYPE_SUBSCRIBE) &&
     (s_axis_tdata_i[3:0] == mcpp_pkg::FLAGS_SUB) &&
     (s_axis_tdata_i[23:8] > 16'd1)) |=> s_axis_tready_o)
    else $error("valid subscribe start stalled input");

endmodule
